// ===== rtl/core/vtp_pkg.sv =====
package vtp_pkg;

    localparam int unsigned DEF_SCREEN_W = 640;
    localparam int unsigned DEF_SCREEN_H = 480;
    localparam int unsigned SCREEN_MAX   = 4096;

    localparam int unsigned CFG_N     = 8;
    localparam int unsigned CFG_SEL_W = $clog2(CFG_N);
    localparam int unsigned CFG_IDX_W = 8;

    // divider operand widths, sized for the largest viewport
    localparam int unsigned NUM_W   = 62;
    localparam int unsigned DEN_W   = 34;
    localparam int unsigned QB      = 32;
    localparam int unsigned DIV_LAT = QB + 3;

    localparam int unsigned QUEUE_D = 4;

    typedef logic signed [31:0] q16_t;

    typedef struct packed {
        q16_t x;
        q16_t y;
        q16_t z;
        q16_t w;
        logic last;
    } clip_t;

    typedef struct packed {
        q16_t w;
        logic outside;
        logic wz;
        logic last;
    } meta_t;

    localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
    localparam q16_t Q16_MIN = 32'sh8000_0000;

    localparam logic [63:0] CFG_RESET [CFG_N] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    function automatic q16_t sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return Q16_MAX;
        end else if (v < -66'sd2147483648) begin
            return Q16_MIN;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/core/vtp_front.sv =====
module vtp_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [63:0]          cfg_q [vtp_pkg::CFG_N],
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [127:0]         s_tdata,
    input  logic                 s_tlast,
    input  logic                 q_full,
    output logic                 q_push,
    output vtp_pkg::clip_t       q_item
);

    logic signed [31:0] m_ent [4][4];
    logic signed [63:0] prod_reg [4][4];
    logic signed [65:0] acc [4];
    vtp_pkg::q16_t      clip_reg [4];
    logic               f1_v_reg, f2_v_reg, last1_reg, last2_reg;
    logic               f_adv;

    always_comb begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                m_ent[r][c] = (r & 1) != 0 ? cfg_q[c * 2 + (r >> 1)][63:32]
                                           : cfg_q[c * 2 + (r >> 1)][31:0];
            end
        end
        for (int c = 0; c < 4; c++) begin
            acc[c] = 66'(prod_reg[c][0]) + 66'(prod_reg[c][1])
                   + 66'(prod_reg[c][2]) + 66'(prod_reg[c][3]);
        end
    end

    assign f_adv    = !f2_v_reg || !q_full;
    assign s_tready = f_adv;
    assign q_push   = f2_v_reg && !q_full;
    assign q_item   = '{x: clip_reg[0], y: clip_reg[1], z: clip_reg[2],
                        w: clip_reg[3], last: last2_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
        end else if (f_adv) begin
            f1_v_reg <= s_tvalid;
            f2_v_reg <= f1_v_reg;
        end
    end

    // products, then exact sum floored to Q16.16 and saturated
    always_ff @(posedge aclk) begin
        if (f_adv) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) begin
                    prod_reg[c][r] <= $signed(s_tdata[32 * r +: 32]) * m_ent[r][c];
                end
                clip_reg[c] <= vtp_pkg::sat32(acc[c] >>> 16);
            end
            last1_reg <= s_tlast;
            last2_reg <= last1_reg;
        end
    end

endmodule

// ===== rtl/core/vtp_queue.sv =====
module vtp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  vtp_pkg::clip_t push_item,
    input  logic           pop,
    output vtp_pkg::clip_t pop_item,
    output logic           full,
    output logic           empty
);

    localparam int unsigned PW = $clog2(vtp_pkg::QUEUE_D);
    localparam int unsigned CW = $clog2(vtp_pkg::QUEUE_D + 1);

    vtp_pkg::clip_t mem_reg [vtp_pkg::QUEUE_D];
    logic [PW-1:0]  wr_reg, rd_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full     = cnt_reg == CW'(vtp_pkg::QUEUE_D);
    assign empty    = cnt_reg == '0;
    assign pop_item = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= wr_reg + PW'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/vtp_div.sv =====
module vtp_div (
    input  logic                                aclk,
    input  logic                                en,
    input  logic signed [vtp_pkg::NUM_W-1:0]    n_i,
    input  logic signed [vtp_pkg::DEN_W-1:0]    d_i,
    output vtp_pkg::q16_t                       q_o
);

    localparam int unsigned NW = vtp_pkg::NUM_W;
    localparam int unsigned DW = vtp_pkg::DEN_W;
    localparam int unsigned QB = vtp_pkg::QB;

    logic [NW-1:0]  an_reg;
    logic [DW-1:0]  ad_reg;
    logic           neg_a_reg;
    logic [DW-1:0]  rem_reg [QB+1];
    logic [QB-1:0]  nq_reg  [QB+1];
    logic [DW-1:0]  d_reg   [QB+1];
    logic           neg_reg [QB+1];
    logic           ovf_reg [QB+1];
    logic           nz_reg  [QB+1];
    logic [NW-QB-1:0] hi;
    logic [QB-1:0]  q;
    vtp_pkg::q16_t  q_reg;

    assign hi  = an_reg[NW-1:QB];
    assign q   = nq_reg[QB];
    assign q_o = q_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            an_reg    <= n_i[NW-1] ? NW'(-n_i) : NW'(n_i);
            ad_reg    <= d_i[DW-1] ? DW'(-d_i) : DW'(d_i);
            neg_a_reg <= n_i[NW-1] ^ d_i[DW-1];
            rem_reg[0] <= DW'(hi);
            nq_reg[0]  <= an_reg[QB-1:0];
            d_reg[0]   <= ad_reg;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= DW'(hi) >= ad_reg;
            nz_reg[0]  <= an_reg == '0;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_step
        logic [DW:0] trial;
        logic        take;
        assign trial = {rem_reg[k-1], nq_reg[k-1][QB-1]};
        assign take  = trial >= {1'b0, d_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? DW'(trial - {1'b0, d_reg[k-1]}) : DW'(trial);
                nq_reg[k]  <= {nq_reg[k-1][QB-2:0], take};
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                nz_reg[k]  <= nz_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (nz_reg[QB]) begin
                q_reg <= '0;
            end else if (ovf_reg[QB]) begin
                q_reg <= neg_reg[QB] ? vtp_pkg::Q16_MIN : vtp_pkg::Q16_MAX;
            end else if (neg_reg[QB]) begin
                q_reg <= (q > 32'h8000_0000) ? vtp_pkg::Q16_MIN : -$signed(q);
            end else begin
                q_reg <= q[31] ? vtp_pkg::Q16_MAX : $signed(q);
            end
        end
    end

endmodule

// ===== rtl/core/vtp_back.sv =====
module vtp_back #(
    parameter int unsigned SCREEN_W = vtp_pkg::DEF_SCREEN_W,
    parameter int unsigned SCREEN_H = vtp_pkg::DEF_SCREEN_H
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  vtp_pkg::clip_t q_item,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [127:0]   m_tdata,
    output logic [1:0]     m_tuser,
    output logic           m_tlast
);

    localparam int unsigned NW = vtp_pkg::NUM_W;
    localparam int unsigned DW = vtp_pkg::DEN_W;
    localparam int unsigned LAT = vtp_pkg::DIV_LAT;
    localparam logic signed [NW-1:0] KX = NW'(SCREEN_W);
    localparam logic signed [NW-1:0] KY = NW'(SCREEN_H);

    logic                 b_adv;
    logic                 b0_v_reg;
    logic signed [NW-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [DW-1:0] d2_reg, d1_reg;
    vtp_pkg::meta_t       meta0_reg;
    logic signed [DW-1:0] cx, cy, cz, cw;
    logic                 mv_reg [LAT];
    vtp_pkg::meta_t       meta_reg [LAT];
    vtp_pkg::q16_t        sx, sy, dz;

    assign b_adv    = !m_tvalid || m_tready;
    assign q_pop    = b_adv && !q_empty;
    assign m_tvalid = mv_reg[LAT-1];
    assign m_tdata  = {meta_reg[LAT-1].w, dz, sy, sx};
    assign m_tuser  = {meta_reg[LAT-1].wz, meta_reg[LAT-1].outside};
    assign m_tlast  = meta_reg[LAT-1].last;

    assign cx = DW'(q_item.x);
    assign cy = DW'(q_item.y);
    assign cz = DW'(q_item.z);
    assign cw = DW'(q_item.w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_v_reg <= 1'b0;
            for (int i = 0; i < LAT; i++) begin
                mv_reg[i] <= 1'b0;
            end
        end else if (b_adv) begin
            b0_v_reg  <= q_pop;
            mv_reg[0] <= b0_v_reg;
            for (int i = 1; i < LAT; i++) begin
                mv_reg[i] <= mv_reg[i-1];
            end
        end
    end

    // numerators, denominators and the view-volume test
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            nx_reg <= (NW'(cx + cw) * KX) <<< 16;
            ny_reg <= (NW'(cw - cy) * KY) <<< 16;
            nz_reg <= NW'(cz) <<< 16;
            d2_reg <= cw <<< 1;
            d1_reg <= cw;
            meta0_reg.w       <= q_item.w;
            meta0_reg.outside <= (cx < -cw) || (cx > cw) || (cy < -cw) || (cy > cw)
                                 || (cz < 0) || (cz > cw);
            meta0_reg.wz      <= q_item.w == '0;
            meta0_reg.last    <= q_item.last;
            meta_reg[0] <= meta0_reg;
            for (int i = 1; i < LAT; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    vtp_div u_div_x (.aclk(aclk), .en(b_adv), .n_i(nx_reg), .d_i(d2_reg), .q_o(sx));
    vtp_div u_div_y (.aclk(aclk), .en(b_adv), .n_i(ny_reg), .d_i(d2_reg), .q_o(sy));
    vtp_div u_div_z (.aclk(aclk), .en(b_adv), .n_i(nz_reg), .d_i(d1_reg), .q_o(dz));

endmodule

// ===== rtl/core/vertex_transform_project_unit.sv =====
// Vertex transform and viewport projection.
// Input channel s_*: one vertex per item, x/y/z/w signed Q16.16 in s_tdata,
// s_tlast marks the final vertex of a mesh.
// Output channel m_*: screen x, screen y (pointing down), depth z/w and clip w
// in m_tdata, the outside-view and zero-w flags in m_tuser, m_tlast copied.
// Config channel cfg_*: eight 64-bit matrix column words, index 0..7; other
// indexes are dropped. cfg_ready is always high; write only while idle.
// Throughput: one item per cycle when nothing stalls. From input accept to
// output valid an item passes two front stages (16 multipliers, loaded on
// the accept edge, then the column sums), the queue memory, one numerator stage
// and the 35-stage pipelined restoring dividers, one quotient bit per step stage.
// A four-item queue splits the front from the back, so each side stalls on its
// own. With m_tvalid high and m_tready low the back pipeline holds and the
// queue fills; s_tready drops once the queue and the last front stage are full.
// Reset empties the pipelines and the queue and loads the identity matrix.
module vertex_transform_project_unit #(
    parameter int unsigned SCREEN_W = vtp_pkg::DEF_SCREEN_W,
    parameter int unsigned SCREEN_H = vtp_pkg::DEF_SCREEN_H
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [127:0]                  s_tdata,   // in_x, in_y, in_z, in_w
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [127:0]                  m_tdata,   // screen_x, screen_y, depth_z, out_w
    output logic [1:0]                    m_tuser,   // outside_view, w_zero
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vtp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);

    logic [63:0]    cfg_q_reg [vtp_pkg::CFG_N];
    logic           q_push, q_pop, q_full, q_empty;
    vtp_pkg::clip_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    // matrix words; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_q_reg <= vtp_pkg::CFG_RESET;
        end else if (cfg_valid
                     && cfg_index < vtp_pkg::CFG_IDX_W'(vtp_pkg::CFG_N)) begin
            cfg_q_reg[cfg_index[vtp_pkg::CFG_SEL_W-1:0]] <= cfg_data;
        end
    end

    vtp_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg_q(cfg_q_reg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tlast(s_tlast), .q_full(q_full), .q_push(q_push), .q_item(push_item)
    );

    vtp_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_item(push_item),
        .pop(q_pop), .pop_item(pop_item), .full(q_full), .empty(q_empty)
    );

    vtp_back #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_item(pop_item), .q_empty(q_empty),
        .q_pop(q_pop), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule

// ===== rtl/core/vtp_checker.sv =====
module vtp_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [127:0]                  m_tdata,
    input logic [1:0]                    m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_wzero_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[1] == (m_tdata[127:96] == 32'h0))
        else $error("zero-w flag disagrees with out_w");

    a_wzero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[95:64] == 32'h0
            || m_tdata[95:64] == 32'h7FFF_FFFF || m_tdata[95:64] == 32'h8000_0000)
        else $error("depth not saturated for zero w");

endmodule

bind vertex_transform_project_unit vtp_checker u_vtp_checker (.*);
